### hw/rtl/are_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ARP resolution engine package
// Shared types, sizes and codes for the ARP cache and pending-request tables.
// ----------------------------------------------------------------------------
package are_pkg;

    localparam int CACHE_ENTRIES   = 16;
    localparam int PENDING_ENTRIES = 16;
    localparam int CIDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int PIDX_W = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;

    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_RX   = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [1:0] KIND_DELIVER = 2'd0;
    localparam logic [1:0] KIND_IPV4    = 2'd1;
    localparam logic [1:0] KIND_ARP     = 2'd2;
    localparam logic [1:0] KIND_DROP    = 2'd3;

    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [15:0] ETH_ARP    = 16'h0806;
    localparam logic [15:0] OP_REQUEST = 16'd1;
    localparam logic [15:0] OP_REPLY   = 16'd2;
    localparam logic [47:0] MAC_BCAST  = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] REG_LOCAL_MAC = 2'd0;
    localparam logic [1:0] REG_LOCAL_IP  = 2'd1;
    localparam logic [1:0] REG_LIFETIME  = 2'd2;
    localparam logic [1:0] REG_RETRY     = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] next_hop_ip;
        logic [15:0] dgram_tag;
        logic [15:0] frame_ethertype;
        logic [47:0] frame_dst_mac;
        logic        payload_ok;
        logic [15:0] rx_arp_opcode;
        logic [47:0] rx_sender_mac;
        logic [31:0] rx_sender_ip;
        logic [31:0] rx_target_ip;
        logic [31:0] elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [47:0] out_dst_mac;
        logic [15:0] out_ethertype;
        logic [15:0] out_arp_opcode;
        logic [47:0] out_target_mac;
        logic [31:0] out_target_ip;
        logic [15:0] out_tag;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [47:0] local_mac;
        logic [31:0] local_ip;
        logic [31:0] lifetime;
        logic [31:0] retry;
    } t_cfg;

    // Saturating 32-bit add.
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage
`default_nettype wire

### hw/rtl/are_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ARP engine configuration registers
// APB-style register file: local MAC, local IP, cache lifetime and retry time.
// ----------------------------------------------------------------------------
module are_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [63:0]   pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output are_pkg::t_cfg      o_cfg
);
    import are_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] w_idx;
    logic       w_hi;

    assign w_idx  = paddr[4:3];
    assign w_hi   = |paddr[2:0];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes at the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_mac <= '0;
            r_cfg.local_ip  <= '0;
            r_cfg.lifetime  <= 32'd30000;
            r_cfg.retry     <= 32'd5000;
        end else if (psel && penable && pwrite && !w_hi) begin
            unique case (w_idx)
                REG_LOCAL_MAC: r_cfg.local_mac <= pwdata[47:0];
                REG_LOCAL_IP:  r_cfg.local_ip  <= pwdata[31:0];
                REG_LIFETIME:  r_cfg.lifetime  <= pwdata[31:0];
                REG_RETRY:     r_cfg.retry     <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        prdata = '0;
        if (!w_hi) begin
            unique case (w_idx)
                REG_LOCAL_MAC: prdata = {16'd0, r_cfg.local_mac};
                REG_LOCAL_IP:  prdata = {32'd0, r_cfg.local_ip};
                REG_LIFETIME:  prdata = {32'd0, r_cfg.lifetime};
                REG_RETRY:     prdata = {32'd0, r_cfg.retry};
                default:       prdata = '0;
            endcase
        end
    end
endmodule
`default_nettype wire

### hw/rtl/arp_resolution_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ARP resolution engine
// Cache of IP-to-MAC bindings and pending-request table for one interface.
// ----------------------------------------------------------------------------
// Usage: command items enter on i_in_valid/o_in_ready (t_in_item) and results
// leave on o_out_valid/i_out_ready (t_out_item); the final result of an item
// has last set. Configuration goes through the APB port: local MAC at 0x00,
// local IP at 0x08, cache lifetime at 0x10, retry time at 0x18 (64-bit data).
// One item is handled at a time by a sequencer that walks the table slots
// with one shared compare/saturating-add unit, one slot per cycle while no
// result is held up. A send missing the cache walks the cache and then the
// pending table, a received ARP the cache, again for a free slot if new, and
// the pending table, and a tick ages the cache then the pending table.
// Each result waits in an output register; while the receiver stalls the
// slot walk pauses on that result. o_in_ready is high only when idle.
// Reset clears the valid bits of both tables and restores the default
// lifetime (30000 ms) and retry (5000 ms); no clearing pass is needed.
// ----------------------------------------------------------------------------
module arp_resolution_engine (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire are_pkg::t_in_item    i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output are_pkg::t_out_item        o_out_item,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [63:0]          pwdata,
    output logic [63:0]               prdata,
    output logic                      pready
);
    import are_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CSRCH, S_PSRCH, S_FREE, S_CFREE, S_RPSRCH, S_REPLY,
        S_CAGE, S_PAGE, S_TEND, S_OUT
    } t_state;

    t_cfg      w_cfg;
    t_state    r_state, r_ret;
    t_in_item  r_in;
    t_out_item r_out;
    logic      r_ovalid;
    logic [7:0] r_idx;
    logic      r_found, r_any;
    logic [PIDX_W-1:0] r_pf;
    logic [4:0] r_cnt;
    logic [31:0] r_hip;

    logic [CACHE_ENTRIES-1:0]   r_cv;
    logic [31:0] r_cip  [CACHE_ENTRIES];
    logic [47:0] r_cmac [CACHE_ENTRIES];
    logic [31:0] r_cage [CACHE_ENTRIES];
    logic [PENDING_ENTRIES-1:0] r_pv;
    logic [31:0] r_pip  [PENDING_ENTRIES];
    logic [15:0] r_ptag [PENDING_ENTRIES];
    logic [31:0] r_ptim [PENDING_ENTRIES];

    logic [CIDX_W-1:0] w_ci;
    logic [PIDX_W-1:0] w_pi;
    logic        w_clast, w_plast;
    logic [31:0] w_sum;
    logic [31:0] w_opnd;
    logic [31:0] w_key;
    logic        w_reply;

    are_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(w_cfg)
    );

    assign w_ci    = r_idx[CIDX_W-1:0];
    assign w_pi    = r_idx[PIDX_W-1:0];
    assign w_clast = (r_idx == 8'(CACHE_ENTRIES - 1));
    assign w_plast = (r_idx == 8'(PENDING_ENTRIES - 1));
    assign w_key   = (r_in.command == CMD_SEND) ? r_in.next_hop_ip : r_in.rx_sender_ip;
    assign w_reply = (r_in.rx_target_ip == w_cfg.local_ip) &&
                     (r_in.rx_arp_opcode == OP_REQUEST);

    // Shared saturating adder for aging.
    assign w_opnd = (r_state == S_CAGE) ? r_cage[w_ci] : r_ptim[w_pi];
    assign w_sum  = sat_add(w_opnd, r_in.elapsed_ms);

    assign o_in_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cv     <= '0;
            r_pv     <= '0;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_any    <= 1'b0;
            r_cnt    <= '0;
            r_pf     <= '0;
        end else begin
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_in    <= i_in_item;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_any   <= 1'b0;
                        r_cnt   <= '0;
                        priority if (i_in_item.command == CMD_SEND)
                            r_state <= S_CSRCH;
                        else if (i_in_item.command == CMD_TICK)
                            r_state <= S_CAGE;
                        else if (i_in_item.command == CMD_RX && i_in_item.payload_ok) begin
                            priority if (i_in_item.frame_ethertype == ETH_IPV4
                                         && i_in_item.frame_dst_mac == w_cfg.local_mac) begin
                                r_out <= '{KIND_DELIVER, '0, '0, '0, '0, '0,
                                           i_in_item.dgram_tag, 1'b1};
                                r_ret <= S_IDLE;
                                r_state <= S_OUT;
                            end else if (i_in_item.frame_ethertype == ETH_ARP)
                                r_state <= S_CSRCH;
                            else
                                r_state <= S_IDLE;
                        end else
                            r_state <= S_IDLE;
                    end
                end
                S_CSRCH: begin
                    // Search cache for the key.
                    if (r_cv[w_ci] && r_cip[w_ci] == w_key) begin
                        r_idx <= '0;
                        if (r_in.command == CMD_SEND) begin
                            r_out <= '{KIND_IPV4, r_cmac[w_ci], ETH_IPV4, '0, '0, '0,
                                       r_in.dgram_tag, 1'b1};
                            r_ret <= S_IDLE;
                            r_state <= S_OUT;
                        end else
                            r_state <= S_RPSRCH;
                    end else if (w_clast) begin
                        r_idx <= '0;
                        r_state <= (r_in.command == CMD_SEND) ? S_PSRCH : S_CFREE;
                    end else
                        r_idx <= r_idx + 8'd1;
                end
                S_CFREE: begin
                    // Learn sender into the first free cache slot.
                    if (!r_cv[w_ci]) begin
                        r_cv[w_ci]   <= 1'b1;
                        r_cip[w_ci]  <= r_in.rx_sender_ip;
                        r_cmac[w_ci] <= r_in.rx_sender_mac;
                        r_cage[w_ci] <= '0;
                        r_idx <= '0;
                        r_state <= S_RPSRCH;
                    end else if (w_clast) begin
                        r_idx <= '0;
                        r_state <= S_RPSRCH;
                    end else
                        r_idx <= r_idx + 8'd1;
                end
                S_PSRCH: begin
                    // Pending lookup; also note the first free slot.
                    if (r_pv[w_pi] && r_pip[w_pi] == w_key)
                        r_state <= S_IDLE;
                    else begin
                        if (!r_pv[w_pi] && !r_found) begin
                            r_found <= 1'b1;
                            r_pf    <= w_pi;
                        end
                        if (w_plast) r_state <= S_FREE;
                        else r_idx <= r_idx + 8'd1;
                    end
                end
                S_FREE: begin
                    if (r_found) begin
                        r_pv[r_pf]   <= 1'b1;
                        r_pip[r_pf]  <= r_in.next_hop_ip;
                        r_ptag[r_pf] <= r_in.dgram_tag;
                        r_ptim[r_pf] <= '0;
                        r_out <= '{KIND_ARP, MAC_BCAST, ETH_ARP, OP_REQUEST, '0,
                                   r_in.next_hop_ip, '0, 1'b1};
                    end else
                        r_out <= '{KIND_DROP, '0, '0, '0, '0, '0, r_in.dgram_tag, 1'b1};
                    r_ret <= S_IDLE;
                    r_state <= S_OUT;
                end
                S_RPSRCH: begin
                    // Release a parked datagram for the sender; a reply may follow it.
                    if (r_pv[w_pi] && r_pip[w_pi] == r_in.rx_sender_ip) begin
                        r_pv[w_pi] <= 1'b0;
                        r_out <= '{KIND_IPV4, r_in.rx_sender_mac, ETH_IPV4, '0, '0, '0,
                                   r_ptag[w_pi], !w_reply};
                        r_any <= 1'b1;
                        r_ret <= S_REPLY;
                        r_state <= S_OUT;
                    end else if (w_plast)
                        r_state <= S_REPLY;
                    else
                        r_idx <= r_idx + 8'd1;
                end
                S_REPLY: begin
                    // Answer a request for the local IP once the output register is free.
                    if (w_reply) begin
                        if (!r_ovalid) begin
                            r_out <= '{KIND_ARP, r_in.rx_sender_mac, ETH_ARP, OP_REPLY,
                                       r_in.rx_sender_mac, r_in.rx_sender_ip, '0, 1'b1};
                            r_ret <= S_IDLE;
                            r_state <= S_OUT;
                        end
                    end else
                        r_state <= S_IDLE;
                end
                S_CAGE: begin
                    if (r_cv[w_ci]) begin
                        r_cage[w_ci] <= w_sum;
                        if (w_sum >= w_cfg.lifetime) r_cv[w_ci] <= 1'b0;
                    end
                    if (w_clast) begin
                        r_idx <= '0;
                        r_state <= S_PAGE;
                    end else
                        r_idx <= r_idx + 8'd1;
                end
                S_PAGE: begin
                    // Age pending slots. Each request is held one step so that
                    // the final one of the tick can carry last.
                    if (r_pv[w_pi] && w_sum >= w_cfg.retry && r_cnt != 5'd16) begin
                        if (!(r_any && r_ovalid)) begin
                            r_ptim[w_pi] <= w_sum - w_cfg.retry;
                            r_hip <= r_pip[w_pi];
                            r_cnt <= r_cnt + 5'd1;
                            r_any <= 1'b1;
                            if (r_any) begin
                                r_out <= '{KIND_ARP, MAC_BCAST, ETH_ARP, OP_REQUEST, '0,
                                           r_hip, '0, 1'b0};
                                r_ret <= w_plast ? S_TEND : S_PAGE;
                                r_state <= S_OUT;
                            end else if (w_plast)
                                r_state <= S_TEND;
                            else
                                r_idx <= r_idx + 8'd1;
                        end
                    end else begin
                        if (r_pv[w_pi]) r_ptim[w_pi] <= w_sum;
                        if (w_plast) r_state <= S_TEND;
                        else r_idx <= r_idx + 8'd1;
                    end
                end
                S_TEND: begin
                    // Send the held request as the final result of the tick.
                    if (!r_any)
                        r_state <= S_IDLE;
                    else if (!r_ovalid) begin
                        r_out <= '{KIND_ARP, MAC_BCAST, ETH_ARP, OP_REQUEST, '0,
                                   r_hip, '0, 1'b1};
                        r_ret <= S_IDLE;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: ;
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_OUT && !r_ovalid) begin
                r_ovalid <= 1'b1;
                r_state <= r_ret;
                r_idx <= r_idx + 8'd1;
            end
        end
    end
endmodule
`default_nettype wire

### tb/sv/arp_resolution_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP resolution engine testbench
// Drives send, receive and tick items through the valid/ready input channel,
// predicts every result with a behavioral model of the cache and the pending
// table, and compares results in order while both sides idle at random.
// ----------------------------------------------------------------------------
module arp_resolution_engine_tb;
    import are_pkg::*;

    localparam int MAX_BURST = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    arp_resolution_engine DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Clock with a 12 ns period.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Predictor state: configuration and both tables.
    logic [47:0] m_mac;
    logic [31:0] m_ip;
    logic [31:0] m_lifetime;
    logic [31:0] m_retry;
    logic        arp_valid [CACHE_ENTRIES];
    logic [31:0] arp_ip    [CACHE_ENTRIES];
    logic [47:0] arp_mac   [CACHE_ENTRIES];
    logic [31:0] arp_age   [CACHE_ENTRIES];
    logic        park_valid [PENDING_ENTRIES];
    logic [31:0] park_ip    [PENDING_ENTRIES];
    logic [15:0] park_tag   [PENDING_ENTRIES];
    logic [31:0] park_timer [PENDING_ENTRIES];

    t_in_item  pending_items [$];
    t_out_item expected_results [$];
    int        errors;
    int        results_seen;
    int        items_sent;
    bit        rx_idle_en;
    bit        tx_idle_en;
    int        rx_hold;
    logic      o_in_ready_q;

    function automatic logic [31:0] add_clamp(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic t_out_item make_result(input logic [1:0] kind, input logic [47:0] dst,
                                              input logic [15:0] et, input logic [15:0] op,
                                              input logic [47:0] tmac, input logic [31:0] tip,
                                              input logic [15:0] tag);
        t_out_item r;
        r.result_kind = kind;
        r.out_dst_mac = dst;
        r.out_ethertype = et;
        r.out_arp_opcode = op;
        r.out_target_mac = tmac;
        r.out_target_ip = tip;
        r.out_tag = tag;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic int lookup_binding(input logic [31:0] ip);
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (arp_valid[i] && arp_ip[i] == ip) return i;
        return -1;
    endfunction

    function automatic int lookup_parked(input logic [31:0] ip);
        for (int i = 0; i < PENDING_ENTRIES; i++)
            if (park_valid[i] && park_ip[i] == ip) return i;
        return -1;
    endfunction

    // Works out the results of one accepted item and updates the tables.
    task automatic resolve_item(input t_in_item it);
        t_out_item burst [$];
        int c;
        int p;
        int f;
        if (it.command == CMD_SEND) begin
            c = lookup_binding(it.next_hop_ip);
            if (c >= 0) begin
                burst.push_back(make_result(KIND_IPV4, arp_mac[c], ETH_IPV4, '0, '0, '0,
                                            it.dgram_tag));
            end else if (lookup_parked(it.next_hop_ip) < 0) begin
                f = -1;
                for (int i = 0; i < PENDING_ENTRIES; i++)
                    if (!park_valid[i] && f < 0) f = i;
                if (f < 0) begin
                    burst.push_back(make_result(KIND_DROP, '0, '0, '0, '0, '0, it.dgram_tag));
                end else begin
                    park_valid[f] = 1'b1;
                    park_ip[f] = it.next_hop_ip;
                    park_tag[f] = it.dgram_tag;
                    park_timer[f] = '0;
                    burst.push_back(make_result(KIND_ARP, MAC_BCAST, ETH_ARP, OP_REQUEST, '0,
                                                it.next_hop_ip, '0));
                end
            end
        end else if (it.command == CMD_RX) begin
            if (it.payload_ok && it.frame_ethertype == ETH_IPV4 && it.frame_dst_mac == m_mac) begin
                burst.push_back(make_result(KIND_DELIVER, '0, '0, '0, '0, '0, it.dgram_tag));
            end else if (it.payload_ok && it.frame_ethertype == ETH_ARP) begin
                if (lookup_binding(it.rx_sender_ip) < 0) begin
                    f = -1;
                    for (int i = 0; i < CACHE_ENTRIES; i++)
                        if (!arp_valid[i] && f < 0) f = i;
                    if (f >= 0) begin
                        arp_valid[f] = 1'b1;
                        arp_ip[f] = it.rx_sender_ip;
                        arp_mac[f] = it.rx_sender_mac;
                        arp_age[f] = '0;
                    end
                end
                p = lookup_parked(it.rx_sender_ip);
                if (p >= 0) begin
                    burst.push_back(make_result(KIND_IPV4, it.rx_sender_mac, ETH_IPV4, '0, '0,
                                                '0, park_tag[p]));
                    park_valid[p] = 1'b0;
                end
                if (it.rx_target_ip == m_ip && it.rx_arp_opcode == OP_REQUEST)
                    burst.push_back(make_result(KIND_ARP, it.rx_sender_mac, ETH_ARP, OP_REPLY,
                                                it.rx_sender_mac, it.rx_sender_ip, '0));
            end
        end else if (it.command == CMD_TICK) begin
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
                if (arp_valid[i]) begin
                    arp_age[i] = add_clamp(arp_age[i], it.elapsed_ms);
                    if (arp_age[i] >= m_lifetime) arp_valid[i] = 1'b0;
                end
            end
            for (int i = 0; i < PENDING_ENTRIES; i++) begin
                if (park_valid[i]) begin
                    park_timer[i] = add_clamp(park_timer[i], it.elapsed_ms);
                    if (park_timer[i] >= m_retry && burst.size() < MAX_BURST) begin
                        burst.push_back(make_result(KIND_ARP, MAC_BCAST, ETH_ARP, OP_REQUEST,
                                                    '0, park_ip[i], '0));
                        park_timer[i] = park_timer[i] - m_retry;
                    end
                end
            end
        end
        if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
        foreach (burst[k]) expected_results.push_back(burst[k]);
    endtask

    // Driver: offers queued items at the falling edge, idling at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready_q) begin
            if (pending_items.size() > 0 && !(tx_idle_en && $urandom_range(99) < 26)) begin
                i_in_item <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Acceptance flag sampled at the rising edge for the driver.
    always @(posedge i_clk) begin
        o_in_ready_q <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            resolve_item(i_in_item);
            items_sent++;
        end
    end

    // Receiver ready: random stalls plus one long hold-off.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !(rx_idle_en && $urandom_range(99) < 26);
        end
    end

    // Monitor: compares each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, o_out_item);
            end else begin
                exp_r = expected_results.pop_front();
                if (exp_r.result_kind !== o_out_item.result_kind ||
                    exp_r.out_dst_mac !== o_out_item.out_dst_mac ||
                    exp_r.out_ethertype !== o_out_item.out_ethertype ||
                    exp_r.out_arp_opcode !== o_out_item.out_arp_opcode ||
                    exp_r.out_target_mac !== o_out_item.out_target_mac ||
                    exp_r.out_target_ip !== o_out_item.out_target_ip ||
                    exp_r.out_tag !== o_out_item.out_tag ||
                    exp_r.last !== o_out_item.last) begin
                    errors++;
                    $display("%0t: mismatch expected %h actual %h", $time, exp_r, o_out_item);
                end
            end
        end
    end

    // Configuration write at 8*index, at falling edges.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_LOCAL_MAC: m_mac = val[47:0];
            REG_LOCAL_IP:  m_ip = val[31:0];
            REG_LIFETIME:  m_lifetime = val[31:0];
            default:       m_retry = val[31:0];
        endcase
    endtask

    // Waits until all queued items are taken and all results have come.
    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic t_in_item blank_item(input logic [1:0] cmd);
        t_in_item it;
        it = '0;
        it.command = cmd;
        return it;
    endfunction

    // Item with every field random.
    function automatic t_in_item random_bits();
        logic [287:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom};
        return t_in_item'(raw[$bits(t_in_item)-1:0]);
    endfunction

    function automatic t_in_item send_item(input logic [31:0] ip, input logic [15:0] tag);
        t_in_item it;
        it = random_bits();
        it.command = CMD_SEND;
        it.next_hop_ip = ip;
        it.dgram_tag = tag;
        return it;
    endfunction

    function automatic t_in_item arp_item(input logic [15:0] op, input logic [47:0] smac,
                                          input logic [31:0] sip, input logic [31:0] tip);
        t_in_item it;
        it = random_bits();
        it.command = CMD_RX;
        it.payload_ok = 1'b1;
        it.frame_ethertype = ETH_ARP;
        it.rx_arp_opcode = op;
        it.rx_sender_mac = smac;
        it.rx_sender_ip = sip;
        it.rx_target_ip = tip;
        return it;
    endfunction

    function automatic t_in_item tick_item(input logic [31:0] ms);
        t_in_item it;
        it = random_bits();
        it.command = CMD_TICK;
        it.elapsed_ms = ms;
        return it;
    endfunction

    // Random item drawn mostly from a small address pool so tables fill and hit.
    function automatic t_in_item random_item();
        t_in_item it;
        logic [31:0] ip;
        int r;
        ip = ($urandom_range(99) < 85) ? 32'h0A00_0000 + $urandom_range(23) : $urandom;
        r = $urandom_range(99);
        if (r < 35) begin
            it = send_item(ip, 16'($urandom));
        end else if (r < 65) begin
            it = arp_item($urandom_range(99) < 70 ? OP_REQUEST : OP_REPLY,
                          48'({$urandom, $urandom}), ip,
                          $urandom_range(1) ? m_ip : $urandom);
            if ($urandom_range(99) < 5) it.payload_ok = 1'b0;
        end else if (r < 75) begin
            it = arp_item(16'($urandom), 48'({$urandom, $urandom}), ip, $urandom);
            it.frame_ethertype = ETH_IPV4;
            it.frame_dst_mac = $urandom_range(1) ? m_mac : 48'({$urandom, $urandom});
            it.payload_ok = ($urandom_range(99) < 90);
        end else if (r < 80) begin
            it = arp_item(16'($urandom), 48'({$urandom, $urandom}), ip, $urandom);
            it.frame_ethertype = 16'($urandom);
            it.command = $urandom_range(1) ? CMD_RX : 2'd3;
        end else begin
            it = tick_item($urandom_range(99) < 90 ? $urandom_range(3000) : $urandom);
        end
        return it;
    endfunction

    initial begin
        t_in_item it;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        results_seen = 0;
        items_sent = 0;
        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
        rx_hold = 0;
        m_mac = '0;
        m_ip = '0;
        m_lifetime = 32'd30000;
        m_retry = 32'd5000;
        for (int i = 0; i < CACHE_ENTRIES; i++) arp_valid[i] = 1'b0;
        for (int i = 0; i < PENDING_ENTRIES; i++) park_valid[i] = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset defaults: IPv4 delivery to the zero MAC, then settings.
        it = arp_item('0, '0, '0, '0);
        it.frame_ethertype = ETH_IPV4;
        it.frame_dst_mac = '0;
        pending_items.push_back(it);
        pending_items.push_back(tick_item(32'hFFFF_FFFF));
        drain();
        write_reg(REG_LOCAL_MAC, 64'h0000_0200_1122_3344);
        write_reg(REG_LOCAL_IP, 64'h0A00_00FE);
        write_reg(REG_LIFETIME, 64'd20000);
        write_reg(REG_RETRY, 64'd1000);

        // Miss, duplicate miss, learn by request for us, hit, reply release.
        pending_items.push_back(send_item(32'h0A00_0001, 16'hFFFF));
        pending_items.push_back(send_item(32'h0A00_0001, 16'h0000));
        pending_items.push_back(arp_item(OP_REQUEST, 48'hFFFF_FFFF_FFFF, 32'h0A00_0001,
                                         32'h0A00_00FE));
        pending_items.push_back(send_item(32'h0A00_0001, 16'h1234));
        pending_items.push_back(arp_item(OP_REQUEST, 48'h0000_0000_0001, 32'h0A00_0001,
                                         32'h0A00_00FE));
        pending_items.push_back(send_item(32'hFFFF_FFFF, 16'h5555));
        pending_items.push_back(arp_item(OP_REPLY, 48'h0000_0000_0000, 32'hFFFF_FFFF,
                                         32'h0A00_00FE));
        it = arp_item(OP_REQUEST, 48'h1, 32'h0A00_0009, 32'h0A00_00FE);
        it.payload_ok = 1'b0;
        pending_items.push_back(it);
        pending_items.push_back(blank_item(2'd3));
        // Fill the pending table past its size, then fire all retries in one tick.
        for (int i = 0; i < PENDING_ENTRIES + 1; i++)
            pending_items.push_back(send_item(32'h0B00_0000 + i, 16'(i)));
        pending_items.push_back(tick_item(32'd1000));
        pending_items.push_back(tick_item(32'd0));
        drain();

        // Retry of zero and saturation; lifetime of one and the maximum.
        write_reg(REG_RETRY, 64'd0);
        write_reg(REG_LIFETIME, 64'd1);
        pending_items.push_back(tick_item(32'hFFFF_FFFF));
        pending_items.push_back(tick_item(32'hFFFF_FFFF));
        drain();
        write_reg(REG_RETRY, 64'hFFFF_FFFF);
        write_reg(REG_LIFETIME, 64'hFFFF_FFFF);
        write_reg(REG_LOCAL_MAC, 64'hFFFF_FFFF_FFFF);
        write_reg(REG_LOCAL_IP, 64'hFFFF_FFFF);
        for (int i = 0; i < PENDING_ENTRIES; i++)
            pending_items.push_back(arp_item(OP_REPLY, 48'({$urandom, $urandom}),
                                             32'h0B00_0000 + i, '0));
        for (int i = 0; i < 4; i++) pending_items.push_back(tick_item(32'hFFFF_FFFF));
        drain();

        // Random phases with different settings.
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_LOCAL_MAC,
                      {16'h0, ($urandom_range(1) ? 48'h0 : 48'({$urandom, $urandom}))});
            write_reg(REG_LOCAL_IP, 64'($urandom));
            write_reg(REG_LIFETIME, ph == 3 ? 64'd1 : 64'($urandom_range(2000, 20000)));
            write_reg(REG_RETRY, ph == 2 ? 64'd1 : 64'($urandom_range(500, 6000)));
            rx_idle_en = (ph != 1);
            tx_idle_en = (ph != 1);
            for (int i = 0; i < 95; i++) pending_items.push_back(random_item());
            if (ph == 0) begin
                // Long receiver hold-off while the sender keeps offering.
                while (pending_items.size() > 60) @(posedge i_clk);
                rx_hold = 300;
            end
            drain();
        end

        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
        $display("Covered %0d items and %0d results across several register settings,",
                 items_sent, results_seen);
        $display("including full tables, retry bursts, saturation and ignored frames.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Overall limit on the run.
    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
